>>> hw/rtl/uniform_grid_cell_list_defines.svh
// Assertion macros for the uniform grid cell list RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef UNIFORM_GRID_CELL_LIST_DEFINES_SVH
`define UNIFORM_GRID_CELL_LIST_DEFINES_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define UGCL_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ugcl assertion failed");

// Expression must never be true outside reset.
`define UGCL_ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ugcl forbidden condition seen");

`else

`define UGCL_ASSERT(name, clk, rst_n, prop)
`define UGCL_ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

>>> hw/rtl/ugcl_pkg.sv
// Shared types and constants for the uniform grid cell list.
// No dependencies; imported by the front end, the back end, the top level and the bench.
`default_nettype none

package ugcl_pkg;

	localparam int POS_W       = 14;
	localparam int FRAC_BITS   = 4;
	localparam int ID_W        = 12;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = 3;
	localparam int MAX_RESULTS = 36;
	// widest cell index over the whole parameter range (256 x 256 grid)
	localparam int CELL_MAX_W  = 16;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [ID_W-1:0]  body_id;
	} in_t;

	typedef struct packed {
		logic [ID_W-1:0]     found_id;
		logic                found;
		logic [STATUS_W-1:0] status;
		logic                last;
	} out_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [STATUS_W-1:0]   status;     // outside-grid verdict
		logic                  empty;      // clamped query block has no cells
		logic [CELL_MAX_W-1:0] cell_addr;  // insert cell, or first cell of query block
		logic [1:0]            xspan;      // query columns minus one
		logic [1:0]            yspan;      // query rows minus one
		logic [ID_W-1:0]       body_id;
	} cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/ugcl_fifo.sv
// Small flop-based queue, first word fall-through.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module ugcl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push, do_pop;

	assign full    = (fill_q == FILL_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/ugcl_front.sv
// Front end: takes input beats, finds the cell, clamps the query block.
// Depends on ugcl_pkg; feeds commands into the command queue.
`default_nettype none

module ugcl_front #(
	parameter int CELL_SIZE = 16,
	parameter int GRID_W    = 64,
	parameter int GRID_H    = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire logic           hold,
	input  wire ugcl_pkg::in_t  item,
	output logic                full,
	output logic                cmd_push,
	output ugcl_pkg::cmd_t      cmd,
	input  wire logic           cmd_full
);

	import ugcl_pkg::*;

	localparam int CELL_FX   = CELL_SIZE * (1 << FRAC_BITS);
	localparam int DIV_SHIFT = 24;
	localparam int RECIP     = (1 << DIV_SHIFT) / CELL_FX;
	localparam int RCP_W     = $clog2(RECIP + 1);
	localparam int PROD_W    = POS_W + RCP_W;
	localparam int CX_W      = $clog2(((1 << POS_W) - 1) / CELL_FX + 1);
	localparam int GX_W      = $clog2(GRID_W);
	localparam int GY_W      = $clog2(GRID_H);
	localparam int GMAX_W    = (GX_W > GY_W) ? GX_W : GY_W;
	localparam int CW        = ((CX_W > GMAX_W) ? CX_W : GMAX_W) + 1;
	localparam int CELL_W    = $clog2(GRID_W * GRID_H);

	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_DIV1  = 7'b0000010,
		F_DIV2  = 7'b0000100,
		F_DIV3  = 7'b0001000,
		F_CLAMP = 7'b0010000,
		F_CELL  = 7'b0100000,
		F_PUSH  = 7'b1000000
	} fstate_t;

	fstate_t              state_q;
	logic [OP_W-1:0]      op_q;
	logic [POS_W-1:0]     px_q, py_q;
	logic [ID_W-1:0]      id_q;
	logic [CX_W-1:0]      qx_q, qy_q;
	logic [POS_W-1:0]     qdx_q, qdy_q;
	logic [CX_W-1:0]      cx_q, cy_q;
	logic [GX_W-1:0]      xsel_q;
	logic [GY_W-1:0]      ysel_q;
	logic [1:0]           xspan_q, yspan_q;
	logic                 empty_q;
	logic [STATUS_W-1:0]  status_q;
	logic [CELL_W-1:0]    cell_q;

	logic                 take;
	logic [PROD_W-1:0]    prod_x, prod_y;
	logic [POS_W-1:0]     rem_x, rem_y;
	logic [CW-1:0]        cxe, cye, x0, x1, y0, y1;
	logic                 in_grid;

	assign full = (state_q != F_IDLE) || hold;
	assign take = push && !full;

	// reciprocal estimate is exact or one low; DIV3 fixes it up
	assign prod_x = PROD_W'(px_q) * PROD_W'(RECIP);
	assign prod_y = PROD_W'(py_q) * PROD_W'(RECIP);
	assign rem_x  = px_q - qdx_q;
	assign rem_y  = py_q - qdy_q;

	always_comb begin
		cxe     = CW'(cx_q);
		cye     = CW'(cy_q);
		x0      = (cxe == '0) ? '0 : cxe - 1'b1;
		y0      = (cye == '0) ? '0 : cye - 1'b1;
		x1      = (cxe + 1'b1 > CW'(GRID_W - 1)) ? CW'(GRID_W - 1) : cxe + 1'b1;
		y1      = (cye + 1'b1 > CW'(GRID_H - 1)) ? CW'(GRID_H - 1) : cye + 1'b1;
		in_grid = (cxe < CW'(GRID_W)) && (cye < CW'(GRID_H));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE:  if (take) state_q <= F_DIV1;
				F_DIV1:  state_q <= F_DIV2;
				F_DIV2:  state_q <= F_DIV3;
				F_DIV3:  state_q <= F_CLAMP;
				F_CLAMP: state_q <= F_CELL;
				F_CELL:  state_q <= F_PUSH;
				F_PUSH:  if (!cmd_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && take) begin
			op_q <= item.operation;
			px_q <= item.pos_x;
			py_q <= item.pos_y;
			id_q <= item.body_id;
		end
		if (state_q == F_DIV1) begin
			qx_q <= prod_x[DIV_SHIFT +: CX_W];
			qy_q <= prod_y[DIV_SHIFT +: CX_W];
		end
		if (state_q == F_DIV2) begin
			qdx_q <= POS_W'(qx_q * CELL_FX);
			qdy_q <= POS_W'(qy_q * CELL_FX);
		end
		if (state_q == F_DIV3) begin
			cx_q <= qx_q + CX_W'({1'b0, rem_x} >= (POS_W + 1)'(CELL_FX));
			cy_q <= qy_q + CX_W'({1'b0, rem_y} >= (POS_W + 1)'(CELL_FX));
		end
		if (state_q == F_CLAMP) begin
			xsel_q   <= (op_q == OP_INSERT) ? GX_W'(cxe) : GX_W'(x0);
			ysel_q   <= (op_q == OP_INSERT) ? GY_W'(cye) : GY_W'(y0);
			xspan_q  <= 2'(x1 - x0);
			yspan_q  <= 2'(y1 - y0);
			empty_q  <= (x0 > x1) || (y0 > y1);
			status_q <= ((op_q == OP_INSERT || op_q == OP_QUERY) && !in_grid)
				? ST_OUTSIDE : ST_OK;
		end
		if (state_q == F_CELL) begin
			cell_q <= CELL_W'(xsel_q * GRID_H + ysel_q);
		end
	end

	assign cmd_push = (state_q == F_PUSH) && !cmd_full;

	always_comb begin
		cmd.op        = op_q;
		cmd.status    = status_q;
		cmd.empty     = empty_q;
		cmd.cell_addr = CELL_MAX_W'(cell_q);
		cmd.xspan     = xspan_q;
		cmd.yspan     = yspan_q;
		cmd.body_id   = id_q;
	end

endmodule

`default_nettype wire

>>> hw/rtl/ugcl_back.sv
// Back end: owns the bucket memories, runs clear sweeps, inserts and queries.
// Depends on ugcl_pkg and the assertion macro header.
`default_nettype none
`include "uniform_grid_cell_list_defines.svh"

module ugcl_back #(
	parameter int GRID_W     = 64,
	parameter int GRID_H     = 64,
	parameter int BUCKET_CAP = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ugcl_pkg::cmd_t  cmd,
	input  wire logic            cmd_empty,
	output logic                 cmd_pop,
	output logic                 res_push,
	output ugcl_pkg::out_t       res_data,
	input  wire logic            res_full,
	output logic                 init_busy
);

	import ugcl_pkg::*;

	localparam int NUM_CELLS = GRID_W * GRID_H;
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int SLOT_W    = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
	localparam int ENT_DEPTH = NUM_CELLS << SLOT_W;
	localparam int ENT_W     = CELL_W + SLOT_W;
	localparam int K_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [6:0] {
		B_SWEEP = 7'b0000001,
		B_IDLE  = 7'b0000010,
		B_CNT   = 7'b0000100,
		B_INS   = 7'b0001000,
		B_ENT   = 7'b0010000,
		B_DONE  = 7'b0100000,
		B_EMIT  = 7'b1000000
	} bstate_t;

	// bucket memories
	logic [CNT_W-1:0] cnt_mem [NUM_CELLS];
	logic [ID_W-1:0]  ent_mem [ENT_DEPTH];
	logic [CNT_W-1:0] cnt_rd_q;
	logic [ID_W-1:0]  ent_rd_q;

	bstate_t             state_q, state_d;
	logic                init_q;
	logic [CELL_W-1:0]   sweep_q;
	logic                pend_valid_q;
	logic [K_W-1:0]      k_q;

	logic [CELL_W-1:0]   cell_q, col_base_q;
	logic [1:0]          xi_q, yi_q, xspan_q, yspan_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     id_q;
	logic [CNT_W-1:0]    n_q, slot_q;
	out_t                pend_q, res_q;

	logic                cnt_re, cnt_we, ent_re, ent_we;
	logic [CELL_W-1:0]   cnt_raddr, cnt_waddr;
	logic [CNT_W-1:0]    cnt_wdata;
	logic [ENT_W-1:0]    ent_raddr, ent_waddr;

	logic [CELL_W-1:0]   cell_in, nxt_cell;
	logic                last_cell, sweep_end, ins_full;
	logic                take_new, need_push, ent_stall, more_slots;

	assign init_busy  = init_q;
	assign cell_in    = cmd.cell_addr[CELL_W-1:0];
	assign last_cell  = (yi_q == yspan_q) && (xi_q == xspan_q);
	assign nxt_cell   = (yi_q != yspan_q) ? cell_q + 1'b1 : col_base_q + CELL_W'(GRID_H);
	assign sweep_end  = (sweep_q == CELL_W'(NUM_CELLS - 1));
	assign ins_full   = (cnt_rd_q >= CNT_W'(BUCKET_CAP));
	// the last id of a query is held back so it can carry the last flag
	assign take_new   = (k_q < K_W'(MAX_RESULTS));
	assign need_push  = take_new && pend_valid_q;
	assign ent_stall  = need_push && res_full;
	assign more_slots = (slot_q + 1'b1) < n_q;

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		res_data  = '0;
		cnt_re    = 1'b0;
		cnt_raddr = cell_q;
		cnt_we    = 1'b0;
		cnt_waddr = cell_q;
		cnt_wdata = '0;
		ent_re    = 1'b0;
		ent_raddr = {cell_q, slot_q[SLOT_W-1:0]};
		ent_we    = 1'b0;
		ent_waddr = {cell_q, cnt_rd_q[SLOT_W-1:0]};
		unique case (state_q)
			B_SWEEP: begin
				cnt_we    = 1'b1;
				cnt_waddr = sweep_q;
				if (sweep_end) state_d = init_q ? B_IDLE : B_EMIT;
			end
			B_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_CLEAR: state_d = B_SWEEP;
						OP_INSERT: begin
							if (cmd.status == ST_OUTSIDE) begin
								state_d = B_EMIT;
							end else begin
								cnt_re    = 1'b1;
								cnt_raddr = cell_in;
								state_d   = B_INS;
							end
						end
						OP_QUERY: begin
							if (cmd.empty) begin
								state_d = B_EMIT;
							end else begin
								cnt_re    = 1'b1;
								cnt_raddr = cell_in;
								state_d   = B_CNT;
							end
						end
						default: state_d = B_EMIT;
					endcase
				end
			end
			B_INS: begin
				if (!res_full) begin
					res_push        = 1'b1;
					res_data.status = ins_full ? ST_FULL : ST_OK;
					res_data.last   = 1'b1;
					if (!ins_full) begin
						ent_we    = 1'b1;
						cnt_we    = 1'b1;
						cnt_wdata = cnt_rd_q + 1'b1;
					end
					state_d = B_IDLE;
				end
			end
			B_CNT: begin
				if (cnt_rd_q == '0) begin
					if (last_cell) begin
						state_d = B_DONE;
					end else begin
						cnt_re    = 1'b1;
						cnt_raddr = nxt_cell;
					end
				end else begin
					ent_re    = 1'b1;
					ent_raddr = {cell_q, {SLOT_W{1'b0}}};
					state_d   = B_ENT;
				end
			end
			B_ENT: begin
				if (!ent_stall) begin
					res_push = need_push;
					res_data = pend_q;
					if (more_slots) begin
						ent_re    = 1'b1;
						ent_raddr = {cell_q, SLOT_W'(slot_q + 1'b1)};
					end else if (last_cell) begin
						state_d = B_DONE;
					end else begin
						cnt_re    = 1'b1;
						cnt_raddr = nxt_cell;
						state_d   = B_CNT;
					end
				end
			end
			B_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					if (pend_valid_q) begin
						res_data      = pend_q;
						res_data.last = 1'b1;
					end else begin
						res_data.status = status_q;
						res_data.last   = 1'b1;
					end
					state_d = B_IDLE;
				end
			end
			B_EMIT: begin
				if (!res_full) begin
					res_push = 1'b1;
					res_data = res_q;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_SWEEP;
			init_q       <= 1'b1;
			sweep_q      <= '0;
			pend_valid_q <= 1'b0;
			k_q          <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_SWEEP) begin
				sweep_q <= sweep_end ? '0 : sweep_q + 1'b1;
				if (sweep_end) init_q <= 1'b0;
			end
			if (state_q == B_IDLE && !cmd_empty) begin
				pend_valid_q <= 1'b0;
				k_q          <= '0;
			end
			if (state_q == B_ENT && !ent_stall && take_new) begin
				pend_valid_q <= 1'b1;
				k_q          <= k_q + 1'b1;
			end
		end
	end

	// walk position and payload
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !cmd_empty) begin
			cell_q     <= cell_in;
			col_base_q <= cell_in;
			xi_q       <= '0;
			yi_q       <= '0;
			xspan_q    <= cmd.xspan;
			yspan_q    <= cmd.yspan;
			status_q   <= cmd.status;
			id_q       <= cmd.body_id;
			res_q      <= '{found_id: '0, found: 1'b0, status: cmd.status, last: 1'b1};
		end
		if (state_q == B_CNT) begin
			n_q    <= cnt_rd_q;
			slot_q <= '0;
		end
		if (state_q == B_ENT && !ent_stall) begin
			if (take_new) begin
				pend_q <= '{found_id: ent_rd_q, found: 1'b1, status: status_q, last: 1'b0};
			end
			if (more_slots) slot_q <= slot_q + 1'b1;
		end
		// step to the next cell of the block: y inner, x outer
		if ((state_q == B_CNT && cnt_rd_q == '0 && !last_cell) ||
		    (state_q == B_ENT && !ent_stall && !more_slots && !last_cell)) begin
			if (yi_q != yspan_q) begin
				yi_q   <= yi_q + 1'b1;
				cell_q <= cell_q + 1'b1;
			end else begin
				xi_q       <= xi_q + 1'b1;
				yi_q       <= '0;
				col_base_q <= col_base_q + CELL_W'(GRID_H);
				cell_q     <= col_base_q + CELL_W'(GRID_H);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_waddr] <= id_q;
		if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
	end

	`UGCL_ASSERT_NEVER(a_res_overflow, clk, arst_n, res_push && res_full)
	`UGCL_ASSERT_NEVER(a_cmd_underflow, clk, arst_n, cmd_pop && cmd_empty)
	`UGCL_ASSERT(a_ins_below_cap, clk, arst_n, ent_we |-> (cnt_rd_q < CNT_W'(BUCKET_CAP)))
	`UGCL_ASSERT(a_result_cap, clk, arst_n, (k_q <= K_W'(MAX_RESULTS)))
	`UGCL_ASSERT(a_init_sweeps, clk, arst_n, init_q |-> (state_q == B_SWEEP))

endmodule

`default_nettype wire

>>> hw/rtl/uniform_grid_cell_list.sv
// Top level of the uniform grid cell list: front end, command queue, back end,
// result queue. Depends on ugcl_pkg, ugcl_front, ugcl_fifo and ugcl_back.
//
//  channel   handshake              beat type          direction
//  item      push / full            ugcl_pkg::in_t     into block
//  result    pop / empty            ugcl_pkg::out_t    out of block
//
// Front end steps each beat through accept, three-step reciprocal divide,
// clamp, cell index multiply and hand-off, taking no new beat until the
// hand-off is done; a 2-entry command queue decouples it. Back end: an insert
// reads the cell count, then writes the id and the count back; a query walks
// the cells of its block and reads out each id found; empty-block queries and
// meaningless ops emit one bare beat; all bound by the single read port of
// each bucket memory. Clear sweeps the count memory. After arst_n releases,
// the same sweep runs over all GRID_W*GRID_H cells with full held high.
// A stalled result queue stops the back end; the front end keeps taking beats
// until the command queue fills.
`default_nettype none

module uniform_grid_cell_list #(
	parameter int CELL_SIZE  = 16,
	parameter int GRID_W     = 64,
	parameter int GRID_H     = 64,
	parameter int BUCKET_CAP = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	output logic                 full,
	input  wire ugcl_pkg::in_t   item,
	output logic                 empty,
	input  wire logic            pop,
	output ugcl_pkg::out_t       result
);

	import ugcl_pkg::*;

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	cmd_t                 cmd_in, cmd_out;
	logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
	out_t                 res_in;
	logic                 res_push, res_full;
	logic                 init_busy;
	logic [$bits(out_t)-1:0] res_out;

	// front end: classify and locate the cell
	ugcl_front #(
		.CELL_SIZE (CELL_SIZE),
		.GRID_W    (GRID_W),
		.GRID_H    (GRID_H)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.hold     (init_busy),
		.item     (item),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in),
		.cmd_full (cmd_full)
	);

	// short queue between front and back
	ugcl_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// back end: bucket memories and the query walk
	ugcl_back #(
		.GRID_W     (GRID_W),
		.GRID_H     (GRID_H),
		.BUCKET_CAP (BUCKET_CAP)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_data  (res_in),
		.res_full  (res_full),
		.init_busy (init_busy)
	);

	// result queue; its head drives the result ports
	ugcl_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign result = out_t'(res_out);

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for uniform_grid_cell_list: a scripted opening, then random traffic.
// Depends on ugcl_pkg and the uniform_grid_cell_list RTL; reads nothing else.

module tb;
	import ugcl_pkg::*;

	// Block sizes; the DUT is built with the same values.
	localparam int CELL_SIZE  = 16;
	localparam int GRID_W     = 64;
	localparam int GRID_H     = 64;
	localparam int BUCKET_CAP = 4;
	// one cell spans this many raw position counts (Q10.4 input)
	localparam int CELL_FX    = CELL_SIZE * (1 << FRAC_BITS);
	localparam int NUM_CELLS  = GRID_W * GRID_H;

	// Operation 3 has no meaning: no state change, one bare beat with last set.
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam int RANDOM_BEATS = 236;
	localparam int MAX_IDLE     = 10;
	localparam int TAIL_CYCLES  = 64;

	// Script rows either carry a hand-typed status or defer to the predictor.
	localparam bit KNOWN     = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		in_t                 beat;
		logic                typed;
		logic [STATUS_W-1:0] want_status;
	} script_row_t;

	// Opening script. At these sizes a 14-bit position divided by 256 never
	// passes 63, so the outside-grid status cannot arise, and nine buckets of
	// four never exceed the result cap, so no query overflows.
	localparam script_row_t SCRIPT [0:23] = '{
		// fresh grid: query at both extremes finds nothing
		{OP_QUERY,  14'h0000, 14'h0000, 12'h000, KNOWN, ST_OK},
		{OP_QUERY,  14'h3fff, 14'h3fff, 12'hfff, KNOWN, ST_OK},
		{OP_NOP,    14'h3fff, 14'h3fff, 12'hfff, KNOWN, ST_OK},
		// fill cell (0,0) to capacity, then one more is dropped
		{OP_INSERT, 14'h0000, 14'h0000, 12'h000, KNOWN, ST_OK},
		{OP_INSERT, 14'h000f, 14'h00ff, 12'hfff, KNOWN, ST_OK},
		{OP_INSERT, 14'h00ff, 14'h0000, 12'h123, KNOWN, ST_OK},
		{OP_INSERT, 14'h00c8, 14'h0064, 12'h456, KNOWN, ST_OK},
		{OP_INSERT, 14'h0001, 14'h0002, 12'h789, KNOWN, ST_FULL},
		// the other corners, two neighbors of (0,0) and cell (2,1)
		{OP_INSERT, 14'h3fff, 14'h3fff, 12'habc, KNOWN, ST_OK},
		{OP_INSERT, 14'h3fff, 14'h0000, 12'h555, KNOWN, ST_OK},
		{OP_INSERT, 14'h0000, 14'h3fff, 12'haaa, KNOWN, ST_OK},
		{OP_INSERT, 14'h0100, 14'h0100, 12'h777, KNOWN, ST_OK},
		{OP_INSERT, 14'h0100, 14'h0000, 12'h0f0, KNOWN, ST_OK},
		{OP_INSERT, 14'h0258, 14'h012c, 12'h3c3, KNOWN, ST_OK},
		// neighborhood walks: clamped at corners and edges, full 3x3 inside
		{OP_QUERY,  14'h0000, 14'h0000, 12'h000, PREDICTED, ST_OK},
		{OP_QUERY,  14'h012c, 14'h012c, 12'hfff, PREDICTED, ST_OK},
		{OP_QUERY,  14'h3fff, 14'h3fff, 12'h000, PREDICTED, ST_OK},
		{OP_QUERY,  14'h3fff, 14'h0000, 12'h000, PREDICTED, ST_OK},
		{OP_QUERY,  14'h0000, 14'h3fff, 12'h000, PREDICTED, ST_OK},
		{OP_NOP,    14'h0000, 14'h0000, 12'h000, KNOWN, ST_OK},
		// clear empties everything
		{OP_CLEAR,  14'h3fff, 14'h3fff, 12'hfff, KNOWN, ST_OK},
		{OP_QUERY,  14'h0000, 14'h0000, 12'h000, KNOWN, ST_OK},
		{OP_INSERT, 14'h1f40, 14'h1f40, 12'h001, KNOWN, ST_OK},
		{OP_QUERY,  14'h1f40, 14'h1fa4, 12'h000, PREDICTED, ST_OK}
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic push   = 1'b0;
	logic pop    = 1'b0;
	in_t  item   = '0;
	logic full;
	logic empty;
	out_t result;

	bit   failed = 1'b0;
	// results still owed by the block, oldest first
	out_t owed_results[$];
	// results caused by the beat just accepted
	out_t op_results[$];

	// Shadow copy of the grid.
	logic [CNT_W-1:0] bucket_fill [NUM_CELLS];
	logic [ID_W-1:0]  bucket_ids  [NUM_CELLS * BUCKET_CAP];

	// when set, that side runs back to back with no idle cycles
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	uniform_grid_cell_list #(
		.CELL_SIZE (CELL_SIZE),
		.GRID_W    (GRID_W),
		.GRID_H    (GRID_H),
		.BUCKET_CAP(BUCKET_CAP)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	always #1 clk = ~clk;

	// Bare result beat: no id, last set.
	function automatic out_t done_beat(input logic [STATUS_W-1:0] st);
		out_t r;
		r        = '0;
		r.status = st;
		r.last   = 1'b1;
		return r;
	endfunction

	// Apply one operation to the shadow grid and list the beats it owes.
	function automatic void apply_grid_op(input in_t b);
		int                  cx, cy, x0, x1, y0, y1, cell_idx, n, x, y, i;
		logic [STATUS_W-1:0] st;
		out_t                r;
		op_results.delete();
		cx = b.pos_x / CELL_FX;
		cy = b.pos_y / CELL_FX;
		st = (cx < GRID_W && cy < GRID_H) ? ST_OK : ST_OUTSIDE;
		case (b.operation)
			OP_CLEAR: begin
				foreach (bucket_fill[c])
					bucket_fill[c] = '0;
				op_results.insert(op_results.size(), done_beat(ST_OK));
			end
			OP_INSERT: begin
				if (st == ST_OK) begin
					cell_idx = cx * GRID_H + cy;
					if (bucket_fill[cell_idx] >= BUCKET_CAP) begin
						st = ST_FULL;
					end else begin
						bucket_ids[cell_idx * BUCKET_CAP + int'(bucket_fill[cell_idx])] =
							b.body_id;
						bucket_fill[cell_idx] = bucket_fill[cell_idx] + 1'b1;
					end
				end
				op_results.insert(op_results.size(), done_beat(st));
			end
			OP_QUERY: begin
				// 3x3 block clamped to the grid, x outer, then y, then bucket order
				x0 = (cx > 0) ? cx - 1 : 0;
				y0 = (cy > 0) ? cy - 1 : 0;
				x1 = (cx + 1 > GRID_W - 1) ? GRID_W - 1 : cx + 1;
				y1 = (cy + 1 > GRID_H - 1) ? GRID_H - 1 : cy + 1;
				for (x = x0; x <= x1; x++) begin
					for (y = y0; y <= y1; y++) begin
						cell_idx = x * GRID_H + y;
						n        = int'(bucket_fill[cell_idx]);
						if (n > BUCKET_CAP)
							n = BUCKET_CAP;
						for (i = 0; i < n; i++) begin
							if (op_results.size() < MAX_RESULTS) begin
								r.found_id = bucket_ids[cell_idx * BUCKET_CAP + i];
								r.found    = 1'b1;
								r.status   = st;
								r.last     = 1'b0;
								op_results.insert(op_results.size(), r);
							end
						end
					end
				end
				if (op_results.size() == 0)
					op_results.insert(0, done_beat(st));
				else
					op_results[op_results.size() - 1].last = 1'b1;
			end
			default: begin
				op_results.insert(op_results.size(), done_beat(ST_OK));
			end
		endcase
	endfunction

	// Offer one beat after a random gap; returns on the edge that takes it.
	// push stays high afterwards: the next call or the caller lowers it.
	task automatic send_beat(input in_t b, input bit typed,
			input logic [STATUS_W-1:0] want_status);
		int gap;
		if ($urandom_range(0, 15) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		item <= b;
		do
			@(posedge clk);
		while (full !== 1'b0);
		apply_grid_op(b);
		if (typed) begin
			op_results.delete();
			op_results.insert(0, done_beat(want_status));
		end
		foreach (op_results[k])
			owed_results.insert(owed_results.size(), op_results[k]);
	endtask

	task automatic field_mismatch(input string name, input logic [ID_W-1:0] want,
			input logic [ID_W-1:0] got);
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		failed = 1'b1;
	endtask

	// Cells picked near the corners and the middle, so buckets actually fill.
	function automatic int hot_cell(input int span);
		case ($urandom_range(0, 2))
			0:       return $urandom_range(0, 1);
			1:       return span / 2 - 1 + $urandom_range(0, 1);
			default: return span - 1 - $urandom_range(0, 1);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pos_in_cell(input int c);
		return POS_W'(c * CELL_FX + int'($urandom_range(0, CELL_FX - 1)));
	endfunction

	// Result side: random pop stalls, every beat checked against the oldest owed.
	initial begin : drain_results
		int   stall;
		out_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				recv_calm = !recv_calm;
			stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
			repeat (stall) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty !== 1'b0);
			if (owed_results.size() == 0) begin
				$display("%0t: result beat with nothing owed, got %h", $time, result);
				failed = 1'b1;
			end else begin
				want = owed_results.pop_front();
				if (result.found_id !== want.found_id)
					field_mismatch("found_id", want.found_id, result.found_id);
				if (result.found !== want.found)
					field_mismatch("found", ID_W'(want.found), ID_W'(result.found));
				if (result.status !== want.status)
					field_mismatch("status", ID_W'(want.status), ID_W'(result.status));
				if (result.last !== want.last)
					field_mismatch("last", ID_W'(want.last), ID_W'(result.last));
			end
		end
	end

	initial begin : stimulus
		int   beats;
		int   clears_left;
		int   burst;
		int   cell_x;
		int   cell_y;
		int   r;
		bit   held_off;
		in_t  b;
		beats       = 0;
		clears_left = 6;
		held_off    = 1'b0;
		b           = '0;
		// the block comes out of reset with every bucket empty
		foreach (bucket_fill[c])
			bucket_fill[c] = '0;

		// Reset, then the block sweeps its count memory with full high;
		// the first beat simply waits on the handshake.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(SCRIPT); i++)
			send_beat(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].want_status);

		while (beats < RANDOM_BEATS) begin
			// once, halfway: let the block drain completely before going on
			if (!held_off && beats >= RANDOM_BEATS / 2) begin
				@(negedge clk);
				push <= 1'b0;
				while (owed_results.size() != 0)
					@(posedge clk);
				held_off = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				// pour a burst of inserts into one bucket, often past capacity, then look around it
				cell_x = hot_cell(GRID_W);
				cell_y = hot_cell(GRID_H);
				burst  = $urandom_range(3, BUCKET_CAP + 2);
				repeat (burst) begin
					b.operation = OP_INSERT;
					b.pos_x     = pos_in_cell(cell_x);
					b.pos_y     = pos_in_cell(cell_y);
					b.body_id   = ID_W'($urandom);
					send_beat(b, PREDICTED, ST_OK);
				end
				b.operation = OP_QUERY;
				b.pos_x     = pos_in_cell(cell_x);
				b.pos_y     = pos_in_cell(cell_y);
				b.body_id   = ID_W'($urandom);
				send_beat(b, PREDICTED, ST_OK);
				beats += burst + 1;
			end else begin
				// lone beat; clears are rare since each one costs a full sweep
				r = $urandom_range(0, 99);
				if (r < 2 && clears_left > 0) begin
					b.operation = OP_CLEAR;
					clears_left--;
				end else if (r < 7) begin
					b.operation = OP_NOP;
				end else if (r < 55) begin
					b.operation = OP_INSERT;
				end else begin
					b.operation = OP_QUERY;
				end
				if ($urandom_range(0, 3) == 0) begin
					b.pos_x = POS_W'($urandom);
					b.pos_y = POS_W'($urandom);
				end else begin
					b.pos_x = pos_in_cell(hot_cell(GRID_W));
					b.pos_y = pos_in_cell(hot_cell(GRID_H));
				end
				b.body_id = ID_W'($urandom);
				send_beat(b, PREDICTED, ST_OK);
				beats++;
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		// keep the clock running to catch stray beats
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!failed)
			$display("uniform_grid_cell_list test passed");
		else
			$display("uniform_grid_cell_list test failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("uniform_grid_cell_list test failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ugcl_pkg.sv
hw/rtl/ugcl_fifo.sv
hw/rtl/ugcl_front.sv
hw/rtl/ugcl_back.sv
hw/rtl/uniform_grid_cell_list.sv
tb/tb.sv
